// ----- rtl/core/dra_pkg.sv -----
// ----------------------------------------------------------------------------
// dra_pkg: shared types and constants of the deadline rate allocator
// field widths, function codes, register indexes and controller/datapath bundles
// ----------------------------------------------------------------------------
package dra_pkg;

   localparam int RATE_W     = 32;
   localparam int GAIN_W     = 16;
   localparam int IVL_W      = 16;
   localparam int TOT_W      = 34;
   localparam int BITS_W     = 40;
   localparam int SLOT_W     = 6;
   localparam int BYTES_W    = 16;
   localparam int QUEUE_W    = 24;
   localparam int FUNC_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_W      = 40;
   localparam int DIV_CNT_W  = 6;
   localparam int SUM_W      = 59;

   // packet function codes
   localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_METER = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_RATE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ALPHA = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_BETA  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_RATE = 3'd4;

   // lower clamp of the estimate is a third of the link rate,
   // taken as (link * ceil(2^33/3)) >> 33, exact for every 32-bit link rate
   localparam logic [RATE_W-1:0] THIRD_RECIP = 32'hAAAA_AAAB;
   localparam int                THIRD_SHIFT = 33;

   typedef enum logic [1:0] {
      DIV_OP_Y  = 2'd0,
      DIV_OP_Q  = 2'd1,
      DIV_OP_FS = 2'd3
   } div_op_type;

   typedef struct packed {
      logic       capture;
      logic       start_meas;
      logic       div_go;
      logic       div_take;
      div_op_type div_op;
      logic       mult;
      logic       sum;
      logic       est_upd;
      logic       meter;
      logic       totals;
      logic       alloc;
      logic       commit;
      logic       ack;
      logic       load_out;
   } dra_cmd_type;

   typedef struct packed {
      logic started;
      logic refine_due;
      logic div_done;
      logic route_data;
      logic route_ack;
   } dra_status_type;

endpackage

// ----- rtl/core/dra_channels.sv -----
// ----------------------------------------------------------------------------
// dra_channels: request and response channels of the rate allocator
// valid/ready handshake with the packet event and allocation result payloads
// ----------------------------------------------------------------------------
interface dra_req_if import dra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SLOT_W-1:0]   flow_slot;
   logic                first_packet;
   logic                rate_ask;
   logic [RATE_W-1:0]   asked_rate;
   logic [BYTES_W-1:0]  packet_bytes;
   logic [RATE_W-1:0]   now;
   logic [QUEUE_W-1:0]  queue_bytes;
   logic                final_packet;
   logic [RATE_W-1:0]   granted_rate;
   logic                granted_valid;

   modport source (output valid, func, flow_slot, first_packet, rate_ask, asked_rate,
                   packet_bytes, now, queue_bytes, final_packet, granted_rate, granted_valid,
                   input ready);
   modport sink (input valid, func, flow_slot, first_packet, rate_ask, asked_rate,
                 packet_bytes, now, queue_bytes, final_packet, granted_rate, granted_valid,
                 output ready);
endinterface

interface dra_rsp_if import dra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              allocation_valid;
   logic [RATE_W-1:0] alloc_rate;
   logic [RATE_W-1:0] bandwidth_estimate;

   modport source (output valid, allocation_valid, alloc_rate, bandwidth_estimate,
                   input ready);
   modport sink (input valid, allocation_valid, alloc_rate, bandwidth_estimate,
                 output ready);
endinterface

// ----- rtl/core/deadline_rate_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// deadline_rate_allocator_unit: per-port deadline-aware rate allocator
// meters traffic, refines the usable bandwidth estimate and grants flow rates
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_port  in         valid/ready          packet event (func, slot, rates, time, queue)
//  rsp_port  out        valid/ready          allocation flag, allocation, estimate
//  csr_*     in         csr_we, no wait      register index and write data
//
//  one request at a time: a meter-only event passes check, meter and done, an ack
//  adds the ack step, a rate request adds totals, one share division, alloc and commit,
//  and refinement adds two divisions, products, sum and estimate update before metering;
//  the serial divider gives one quotient bit a cycle, 40 bits for each division
//  reset is synchronous; flow flags clear at once, flow tables need no clearing
//  a finished response waits in the output register while the next request is taken;
//  the next response stalls until the waiting one is accepted
// ----------------------------------------------------------------------------
module deadline_rate_allocator_unit import dra_pkg::*; #(
   parameter int FLOW_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   dra_req_if.sink               req_port,
   dra_rsp_if.source             rsp_port,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dra_cmd_type    cmd;
   dra_status_type status;
   logic           ctrl_req_ready;
   logic           ctrl_rsp_valid;

   // sequencer
   dra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: one command per cycle, status back to the sequencer
   dra_datapath #(
      .FLOW_SLOTS (FLOW_SLOTS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .in_func                (req_port.func),
      .in_flow_slot           (req_port.flow_slot),
      .in_first_packet        (req_port.first_packet),
      .in_rate_ask            (req_port.rate_ask),
      .in_asked_rate          (req_port.asked_rate),
      .in_packet_bytes        (req_port.packet_bytes),
      .in_now                 (req_port.now),
      .in_queue_bytes         (req_port.queue_bytes),
      .in_final_packet        (req_port.final_packet),
      .in_granted_rate        (req_port.granted_rate),
      .in_granted_valid       (req_port.granted_valid),
      .out_allocation_valid   (rsp_port.allocation_valid),
      .out_alloc_rate         (rsp_port.alloc_rate),
      .out_bandwidth_estimate (rsp_port.bandwidth_estimate)
   );

   assign req_port.ready = ctrl_req_ready;
   assign rsp_port.valid = ctrl_rsp_valid;

endmodule

// ----- rtl/core/dra_divider.sv -----
// ----------------------------------------------------------------------------
// dra_divider: shared serial divider
// restoring unsigned division, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dra_divider import dra_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [RATE_W-1:0]    rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [RATE_W-1:0]    dvs_ff;
   logic [RATE_W:0]      trial;
   logic [RATE_W:0]      diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/dra_datapath.sv -----
// ----------------------------------------------------------------------------
// dra_datapath: estimate, totals, flow tables and result registers
// executes one controller command per cycle
// ----------------------------------------------------------------------------
module dra_datapath import dra_pkg::*; #(
   parameter int FLOW_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dra_cmd_type           cmd,
   output dra_status_type        status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [FUNC_W-1:0]     in_func,
   input  logic [SLOT_W-1:0]     in_flow_slot,
   input  logic                  in_first_packet,
   input  logic                  in_rate_ask,
   input  logic [RATE_W-1:0]     in_asked_rate,
   input  logic [BYTES_W-1:0]    in_packet_bytes,
   input  logic [RATE_W-1:0]     in_now,
   input  logic [QUEUE_W-1:0]    in_queue_bytes,
   input  logic                  in_final_packet,
   input  logic [RATE_W-1:0]     in_granted_rate,
   input  logic                  in_granted_valid,
   output logic                  out_allocation_valid,
   output logic [RATE_W-1:0]     out_alloc_rate,
   output logic [RATE_W-1:0]     out_bandwidth_estimate
);

   localparam int IDX_W = $clog2(FLOW_SLOTS);
   localparam int CNT_W = $clog2(FLOW_SLOTS + 1);
   localparam int SW    = TOT_W + 2;

   function automatic logic [TOT_W-1:0] sat_total(input logic signed [SW-1:0] v);
      logic [TOT_W-1:0] r;
      if (v < 0)
         r = '0;
      else if (v > $signed({2'b00, {TOT_W{1'b1}}}))
         r = '1;
      else
         r = v[TOT_W-1:0];
      return r;
   endfunction

   // configuration
   logic [RATE_W-1:0] link_ff, floor_ff;
   logic [GAIN_W-1:0] alpha_ff, beta_ff;
   logic [IVL_W-1:0]  ivl_ff;

   // port state
   logic [RATE_W-1:0] est_ff, est_in;
   logic [TOT_W-1:0]  ta_ff, ta_in, td_ff, td_in;
   logic [RATE_W-1:0] last_ff;
   logic              started_ff;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [FLOW_SLOTS-1:0] active_ff, known_ff, finished_ff;
   logic [CNT_W-1:0]  count_ff;

   // latched event
   logic [FUNC_W-1:0]  func_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               first_ff, req_ff, lastpkt_ff, gvalid_ff;
   logic [RATE_W-1:0]  desired_ff, now_ff, granted_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [QUEUE_W-1:0] queue_ff;

   // working registers
   logic [BITS_W-1:0]        y_ff;
   logic [QUEUE_W-1:0]       q_ff;
   logic [RATE_W-1:0]        lo_ff;
   logic signed [SW-1:0]     fs_ff;
   logic                     fs_neg_ff;
   logic signed [SUM_W-1:0]  m1_ff, v_ff;
   logic [GAIN_W+QUEUE_W-1:0] m2_ff;
   logic [RATE_W-1:0]        alloc_ff, alloc_in;
   logic                     res_valid_ff;

   // flow tables
   logic [RATE_W-1:0] demand_mem [FLOW_SLOTS];
   logic [RATE_W-1:0] rate_mem   [FLOW_SLOTS];
   logic [RATE_W-1:0] dem_rd_ff, rate_rd_ff;

   // output register
   logic              outv_ff;
   logic [RATE_W-1:0] outa_ff, oute_ff;

   logic [IDX_W-1:0]   idx;
   logic               in_table;
   logic [RATE_W-1:0]  delta;
   logic [DIV_W-1:0]   dvd;
   logic [RATE_W-1:0]  dvs;
   logic               div_done;
   logic [DIV_W-1:0]   quot;
   logic signed [SW-1:0] fs_num, fs_mag;
   logic [CNT_W-1:0]   n_val;
   logic signed [BITS_W+1:0] est_diff;
   logic [2*RATE_W-1:0] third_prod;
   logic [SUM_W-17:0]  vq;
   logic [RATE_W-1:0]  est_b;
   logic [BITS_W:0]    meter_sum;
   logic [RATE_W-1:0]  old_d, old_a;
   logic signed [SW-1:0] left, des_s, cand, cand2, floor_s;
   logic               rate_we;

   assign idx      = IDX_W'(slot_ff);
   assign in_table = (int'(slot_ff) < FLOW_SLOTS);
   assign delta    = now_ff - last_ff;

   assign status.started    = started_ff;
   assign status.refine_due = (delta != '0) && (delta > {{(RATE_W-IVL_W){1'b0}}, ivl_ff});
   assign status.div_done   = div_done;
   assign status.route_data = in_table && (func_ff == FUNC_DATA) && req_ff && !finished_ff[idx];
   assign status.route_ack  = in_table && (func_ff == FUNC_ACK) && active_ff[idx];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff  <= '0;
         alpha_ff <= '0;
         beta_ff  <= '0;
         ivl_ff   <= IVL_W'(1);
         floor_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINK_RATE:  link_ff  <= csr_wdata[RATE_W-1:0];
            CSR_GAIN_ALPHA: alpha_ff <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_BETA:  beta_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_INTERVAL:   ivl_ff   <= csr_wdata[IVL_W-1:0];
            CSR_FLOOR_RATE: floor_ff <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // event capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= in_func;
         slot_ff    <= in_flow_slot;
         first_ff   <= in_first_packet;
         req_ff     <= in_rate_ask;
         desired_ff <= in_asked_rate;
         bytes_ff   <= in_packet_bytes;
         now_ff     <= in_now;
         queue_ff   <= in_queue_bytes;
         lastpkt_ff <= in_final_packet;
         granted_ff <= in_granted_rate;
         gvalid_ff  <= in_granted_valid;
      end
   end

   // divider operands
   assign fs_num = $signed({{(SW-RATE_W){1'b0}}, est_ff}) - $signed({2'b00, td_ff});
   assign fs_mag = fs_num[SW-1] ? -fs_num : fs_num;
   assign n_val  = (count_ff == '0) ? CNT_W'(1) : count_ff;

   always_comb begin
      case (cmd.div_op)
         DIV_OP_Y: begin
            dvd = bits_ff;
            dvs = delta;
         end
         DIV_OP_Q: begin
            dvd = DIV_W'(queue_ff);
            dvs = delta;
         end
         default: begin
            dvd = DIV_W'(fs_mag);
            dvs = RATE_W'(n_val);
         end
      endcase
   end

   dra_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_go && (cmd.div_op == DIV_OP_FS))
         fs_neg_ff <= fs_num[SW-1];
      if (cmd.div_take) begin
         case (cmd.div_op)
            DIV_OP_Y:  y_ff  <= quot;
            DIV_OP_Q:  q_ff  <= quot[QUEUE_W-1:0];
            default:   fs_ff <= fs_neg_ff ? -$signed({1'b0, quot[TOT_W:0]})
                                          :  $signed({1'b0, quot[TOT_W:0]});
         endcase
      end
   end

   // estimate refinement products and sum
   assign est_diff   = $signed({{(BITS_W+2-RATE_W){1'b0}}, est_ff}) - $signed({2'b00, y_ff});
   assign third_prod = link_ff * THIRD_RECIP;

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         m1_ff <= $signed({1'b0, alpha_ff}) * est_diff;
         m2_ff <= beta_ff * q_ff;
         lo_ff <= RATE_W'(third_prod >> THIRD_SHIFT);
      end
      if (cmd.sum)
         v_ff <= $signed({{(SUM_W-RATE_W-16){1'b0}}, est_ff, 16'h0000}) + m1_ff
                 - $signed({{(SUM_W-GAIN_W-QUEUE_W){1'b0}}, m2_ff});
   end

   // clamp to [link/3, link]
   always_comb begin
      vq    = v_ff[SUM_W-1] ? '0 : v_ff[SUM_W-1:16];
      est_b = (vq > {{(SUM_W-16-RATE_W){1'b0}}, link_ff}) ? link_ff : vq[RATE_W-1:0];
      est_in = (est_b < lo_ff) ? lo_ff : est_b;
   end

   always_ff @(posedge clock) begin
      if (reset)
         est_ff <= '0;
      else if (csr_we && (csr_index == CSR_LINK_RATE))
         est_ff <= csr_wdata[RATE_W-1:0];
      else if (cmd.est_upd)
         est_ff <= est_in;
   end

   // meter and measurement time
   assign meter_sum = {1'b0, bits_ff} + {{(BITS_W-BYTES_W-2){1'b0}}, bytes_ff, 3'b000};

   always_comb begin
      bits_in = bits_ff;
      if (cmd.est_upd)
         bits_in = '0;
      else if (cmd.meter)
         bits_in = meter_sum[BITS_W] ? '1 : meter_sum[BITS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff    <= '0;
         last_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         bits_ff <= bits_in;
         if (cmd.start_meas || cmd.est_upd)
            last_ff <= now_ff;
         if (cmd.start_meas)
            started_ff <= 1'b1;
      end
   end

   // allocation
   assign old_d   = known_ff[idx] ? dem_rd_ff : '0;
   assign old_a   = known_ff[idx] ? rate_rd_ff : '0;
   assign left    = $signed({{(SW-RATE_W){1'b0}}, est_ff}) - $signed({2'b00, ta_ff});
   assign des_s   = $signed({{(SW-RATE_W){1'b0}}, desired_ff});
   assign floor_s = $signed({{(SW-RATE_W){1'b0}}, floor_ff});

   always_comb begin
      cand  = (left > des_s) ? des_s + fs_ff : left;
      cand2 = (cand < floor_s) ? floor_s : cand;
      alloc_in = (cand2 > $signed({{(SW-RATE_W){1'b0}}, {RATE_W{1'b1}}})) ? '1
                                                                          : cand2[RATE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc)
         alloc_ff <= alloc_in;
   end

   // totals
   always_comb begin
      ta_in = ta_ff;
      td_in = td_ff;
      if (cmd.totals) begin
         td_in = sat_total($signed({2'b00, td_ff}) - $signed({{(SW-RATE_W){1'b0}}, old_d})
                           + des_s);
         ta_in = sat_total($signed({2'b00, ta_ff}) - $signed({{(SW-RATE_W){1'b0}}, old_a}));
      end else if (cmd.commit) begin
         ta_in = sat_total($signed({2'b00, ta_ff})
                           + $signed({{(SW-RATE_W){1'b0}}, alloc_ff}));
      end else if (cmd.ack) begin
         if (lastpkt_ff) begin
            ta_in = sat_total($signed({2'b00, ta_ff})
                              - $signed({{(SW-RATE_W){1'b0}}, rate_rd_ff}));
            td_in = sat_total($signed({2'b00, td_ff})
                              - $signed({{(SW-RATE_W){1'b0}}, dem_rd_ff}));
         end else if (gvalid_ff) begin
            ta_in = sat_total($signed({2'b00, ta_ff})
                              - $signed({{(SW-RATE_W){1'b0}}, rate_rd_ff})
                              + $signed({{(SW-RATE_W){1'b0}}, granted_ff}));
         end
      end
   end

   // totals, flow flags, active count and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff        <= '0;
         td_ff        <= '0;
         active_ff    <= '0;
         known_ff     <= '0;
         finished_ff  <= '0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         ta_ff <= ta_in;
         td_ff <= td_in;
         if (cmd.capture)
            res_valid_ff <= 1'b0;
         if (cmd.totals && first_ff && !active_ff[idx]) begin
            active_ff[idx] <= 1'b1;
            count_ff       <= count_ff + 1'b1;
         end
         if (cmd.commit) begin
            known_ff[idx] <= 1'b1;
            res_valid_ff  <= 1'b1;
         end
         if (cmd.ack && lastpkt_ff) begin
            finished_ff[idx] <= 1'b1;
            active_ff[idx]   <= 1'b0;
            known_ff[idx]    <= 1'b0;
            if (count_ff != '0)
               count_ff <= count_ff - 1'b1;
         end
      end
   end

   // demand and rate tables, registered read at the latched slot
   assign rate_we = cmd.commit || (cmd.ack && !lastpkt_ff && gvalid_ff);

   always_ff @(posedge clock) begin
      if (cmd.commit)
         demand_mem[idx] <= desired_ff;
      if (rate_we)
         rate_mem[idx] <= cmd.commit ? alloc_ff : granted_ff;
      dem_rd_ff  <= demand_mem[idx];
      rate_rd_ff <= rate_mem[idx];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         outv_ff <= res_valid_ff;
         outa_ff <= res_valid_ff ? alloc_ff : '0;
         oute_ff <= est_ff;
      end
   end

   assign out_allocation_valid   = outv_ff;
   assign out_alloc_rate         = outa_ff;
   assign out_bandwidth_estimate = oute_ff;

endmodule

// ----- rtl/core/dra_ctrl.sv -----
// ----------------------------------------------------------------------------
// dra_ctrl: sequencer of the rate allocator
// walks one request through refinement, metering and the flow update
// ----------------------------------------------------------------------------
module dra_ctrl import dra_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output dra_cmd_type    cmd,
   input  dra_status_type status
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_CHECK  = 16'h0002,
      ST_DIV_Y  = 16'h0004,
      ST_DIV_Q  = 16'h0008,
      ST_Q_GO   = 16'h0010,
      ST_MUL    = 16'h0020,
      ST_SUM    = 16'h0040,
      ST_EST    = 16'h0080,
      ST_METER  = 16'h0100,
      ST_TOTALS = 16'h0200,
      ST_FS_GO  = 16'h0400,
      ST_DIV_FS = 16'h0800,
      ST_ALLOC  = 16'h1000,
      ST_COMMIT = 16'h2000,
      ST_ACK    = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.div_op   = DIV_OP_Y;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.started) begin
               cmd.start_meas = 1'b1;
               state_in       = ST_METER;
            end else if (status.refine_due) begin
               cmd.div_go = 1'b1;
               state_in   = ST_DIV_Y;
            end else begin
               state_in = ST_METER;
            end
         end
         ST_DIV_Y: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_Q_GO;
            end
         end
         ST_Q_GO: begin
            // launch the backlog division
            cmd.div_op = DIV_OP_Q;
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_Q;
         end
         ST_DIV_Q: begin
            cmd.div_op = DIV_OP_Q;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_EST;
         end
         ST_EST: begin
            cmd.est_upd = 1'b1;
            state_in    = ST_METER;
         end
         ST_METER: begin
            cmd.meter = 1'b1;
            if (status.route_data)
               state_in = ST_TOTALS;
            else if (status.route_ack)
               state_in = ST_ACK;
            else
               state_in = ST_DONE;
         end
         ST_TOTALS: begin
            cmd.totals = 1'b1;
            state_in   = ST_FS_GO;
         end
         ST_FS_GO: begin
            cmd.div_op = DIV_OP_FS;
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_FS;
         end
         ST_DIV_FS: begin
            cmd.div_op = DIV_OP_FS;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_ACK: begin
            cmd.ack  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
